### hdl/command_line_argument_splitter_core_assert.svh
// Assertion macros for the command-line argument splitter.
// Uses the clk and rst names of the including module; no other dependencies.
`ifndef COMMAND_LINE_ARGUMENT_SPLITTER_CORE_ASSERT_SVH
`define COMMAND_LINE_ARGUMENT_SPLITTER_CORE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define CLAS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An implication checked in the same cycle outside reset.
`define CLAS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hdl/clas_pkg.sv
// Shared types and constants for the command-line argument splitter.
// Used by the controller, the datapath and the top level; no dependencies.
package clas_pkg;

  // Longest backslash run that is counted before overflow results begin.
  localparam int MAX_BACKSLASH_RUN_DEF = 63;

  // Character constants.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  // Request kinds on the input stream.
  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_EOL  = 1'b1;

  // Register indexes on the configuration port.
  localparam logic REG_HAS_PROG  = 1'b0;
  localparam logic REG_SKIP_PROG = 1'b1;

  // Result kinds.
  typedef enum logic [1:0] {
    K_CHAR = 2'd0,
    K_END  = 2'd1,
    K_OVF  = 2'd2
  } kind_t;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_PROG = 2'd0,
    PH_SKIP = 2'd1,
    PH_ARG  = 2'd2
  } phase_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_BS   = 3'b010,
    ST_TAIL = 3'b100
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // an input transfer completes this cycle
    logic bs_step;   // a backslash result transfers this cycle
    logic tail_sel;  // drive the tail result onto the output
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dec_has_bs;    // the offered item flushes backslashes
    logic dec_has_tail;  // the offered item ends with a tail result
    logic bs_one;        // one backslash result remains
    logic tail_pending;  // the item in flight has a tail result
  } dp_status_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) || (c == CH_SPACE);
  endfunction

endpackage

### hdl/clas_ctrl.sv
// Controller state machine for the command-line argument splitter.
// Depends on clas_pkg; sequences backslash and tail results of one item.
module clas_ctrl
  import clas_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic       m_tlast,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  ctl_state_t state;
  ctl_state_t state_next;
  logic       accept;
  logic       fire;
  logic       done;

  // Output handshake and end of the current item.
  assign m_tvalid = (state != ST_IDLE);
  assign m_tlast  = (state == ST_TAIL) ||
                    ((state == ST_BS) && status.bs_one && !status.tail_pending);
  assign fire     = m_tvalid && m_tready;
  assign done     = fire && m_tlast;
  assign s_tready = (state == ST_IDLE) || done;
  assign accept   = s_tvalid && s_tready;

  assign cmd.load     = accept;
  assign cmd.bs_step  = fire && (state == ST_BS);
  assign cmd.tail_sel = (state == ST_TAIL);

  // Next state.
  always_comb begin
    state_next = state;
    if (accept) begin
      if (status.dec_has_bs) begin
        state_next = ST_BS;
      end else if (status.dec_has_tail) begin
        state_next = ST_TAIL;
      end else begin
        state_next = ST_IDLE;
      end
    end else if (done) begin
      state_next = ST_IDLE;
    end else if (fire && (state == ST_BS) && status.bs_one) begin
      state_next = ST_TAIL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hdl/clas_datapath.sv
// Datapath of the command-line argument splitter: parser state, decision logic,
// backslash flush counter and tail result register. Depends on clas_pkg.
module clas_datapath
  import clas_pkg::*;
#(
  parameter int MAX_BACKSLASH_RUN = MAX_BACKSLASH_RUN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       has_program_name,
  input  logic       skip_program_name,
  input  logic       req_type,
  input  logic [7:0] in_char,
  input  ctl_cmd_t   cmd,
  output dp_status_t status,
  output logic [1:0] kind,
  output logic [7:0] out_char
);

  // Parser state.
  phase_t     phase;
  logic       in_quotes;
  logic       quote_pending;
  logic [5:0] bs_count;

  // Item in flight.
  logic [5:0] bs_rem;
  logic       tail_en;
  kind_t      tail_kind;
  logic [7:0] tail_char;

  // Decision for the offered item.
  phase_t     ph;
  phase_t     phase_next;
  logic       in_quotes_next;
  logic       quote_pending_next;
  logic [5:0] bs_count_next;
  logic [5:0] d_nbs;
  logic       d_tail;
  kind_t      d_kind;
  logic [7:0] d_char;
  logic       handled;
  logic       run_plain;
  logic       ws;

  assign ws = is_ws(in_char);

  // Work out the new state and the results of the offered item.
  always_comb begin
    if (phase == PH_ARG) begin
      ph = PH_ARG;
    end else if ((phase == PH_PROG) && has_program_name) begin
      ph = PH_PROG;
    end else begin
      ph = PH_SKIP;
    end
    phase_next         = ph;
    in_quotes_next     = in_quotes;
    quote_pending_next = quote_pending;
    bs_count_next      = bs_count;
    d_nbs              = '0;
    d_tail             = 1'b0;
    d_kind             = K_CHAR;
    d_char             = '0;
    handled            = 1'b0;
    run_plain          = 1'b0;

    if (req_type == REQ_EOL) begin
      // End of line: flush, close the argument and start over.
      if (ph == PH_PROG) begin
        d_tail = !skip_program_name;
      end else if (ph == PH_ARG) begin
        d_nbs  = bs_count;
        d_tail = 1'b1;
      end
      d_kind             = K_END;
      phase_next         = has_program_name ? PH_PROG : PH_SKIP;
      in_quotes_next     = 1'b0;
      quote_pending_next = 1'b0;
      bs_count_next      = '0;
    end else begin
      case (ph)
        PH_PROG: begin
          // Program name: quotes only toggle, backslashes are literal.
          if (in_char == CH_QUOTE) begin
            in_quotes_next = !in_quotes;
          end else if (!in_quotes && ws) begin
            d_tail         = !skip_program_name;
            d_kind         = K_END;
            phase_next     = PH_SKIP;
            in_quotes_next = 1'b0;
          end else begin
            d_tail = !skip_program_name;
            d_char = in_char;
          end
        end
        PH_ARG: begin
          // A quote seen in a span is either doubled or closes the span.
          if (quote_pending) begin
            quote_pending_next = 1'b0;
            if (in_char == CH_QUOTE) begin
              d_tail  = 1'b1;
              d_char  = CH_QUOTE;
              handled = 1'b1;
            end else begin
              in_quotes_next = 1'b0;
            end
          end
          // A backslash run either grows or is resolved by this byte.
          if (!handled && (bs_count != '0)) begin
            if (in_char == CH_BSL) begin
              if (bs_count >= 6'(MAX_BACKSLASH_RUN)) begin
                d_tail = 1'b1;
                d_kind = K_OVF;
              end else begin
                bs_count_next = bs_count + 6'd1;
              end
              handled = 1'b1;
            end else begin
              bs_count_next = '0;
              if (in_char == CH_QUOTE) begin
                d_nbs = bs_count >> 1;
                if (bs_count[0]) begin
                  d_tail  = 1'b1;
                  d_char  = CH_QUOTE;
                  handled = 1'b1;
                end
              end else begin
                d_nbs = bs_count;
              end
            end
          end
          run_plain = !handled;
        end
        default: begin
          // Between arguments: the first non-blank byte opens one.
          if (!ws) begin
            phase_next         = PH_ARG;
            in_quotes_next     = 1'b0;
            quote_pending_next = 1'b0;
            bs_count_next      = '0;
            run_plain          = 1'b1;
          end
        end
      endcase

      // A byte inside an argument with nothing pending.
      if (run_plain) begin
        if (in_char == CH_BSL) begin
          bs_count_next = 6'd1;
        end else if (in_char == CH_QUOTE) begin
          if (!in_quotes_next) begin
            in_quotes_next = 1'b1;
          end else begin
            quote_pending_next = 1'b1;
          end
        end else if (!in_quotes_next && ws) begin
          d_tail         = 1'b1;
          d_kind         = K_END;
          phase_next     = PH_SKIP;
          in_quotes_next = 1'b0;
        end else begin
          d_tail = 1'b1;
          d_char = in_char;
        end
      end
    end
  end

  // Parser state is updated when the item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_PROG;
      in_quotes     <= 1'b0;
      quote_pending <= 1'b0;
      bs_count      <= '0;
      bs_rem        <= '0;
      tail_en       <= 1'b0;
    end else if (cmd.load) begin
      phase         <= phase_next;
      in_quotes     <= in_quotes_next;
      quote_pending <= quote_pending_next;
      bs_count      <= bs_count_next;
      bs_rem        <= d_nbs;
      tail_en       <= d_tail;
    end else if (cmd.bs_step) begin
      bs_rem <= bs_rem - 6'd1;
    end
  end

  // Tail payload holds no control meaning.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tail_kind <= d_kind;
      tail_char <= d_char;
    end
  end

  assign status.dec_has_bs   = (d_nbs != '0);
  assign status.dec_has_tail = d_tail;
  assign status.bs_one       = (bs_rem == 6'd1);
  assign status.tail_pending = tail_en;

  // Output selection: flushed backslash or the tail result.
  assign kind     = cmd.tail_sel ? tail_kind : K_CHAR;
  assign out_char = cmd.tail_sel ? tail_char : CH_BSL;

endmodule

### hdl/command_line_argument_splitter_core.sv
// Command-line argument splitter: splits a byte stream into arguments by Windows rules.
// Holds the configuration registers. Uses clas_pkg, clas_ctrl, clas_datapath and the
// assertion macro header.
//
// Input stream (s_*): one transfer per command-line byte (s_tuser = 0, byte in s_tdata)
// or an end-of-line marker (s_tuser = 1, s_tdata ignored).
// Output stream (m_*): the results of each input, in order; m_tlast marks the last
// result of one input. m_tuser is the kind (character, argument end, backslash
// overflow) and m_tdata the character, zero for other kinds.
// An input that causes no result produces no output transfer.
// Results appear the cycle after the input transfer. A multi-result input holds the
// output until all transfer: up to 63 flushed backslashes, from the datapath flush
// counter, then one tail result. The next input is taken in the cycle that the last
// result transfers, so with one result per input and no stall the block runs one byte
// a cycle. On a receiver stall the current result holds and no input is taken. Reset
// empties the block and returns to the start of a line with a program name expected; the
// user writes configuration over the APB port while the block is idle; not enforced.
module command_line_argument_splitter_core
  import clas_pkg::*;
#(
  parameter int MAX_BACKSLASH_RUN = MAX_BACKSLASH_RUN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_char
  input  logic        s_tuser,   // [0] req_type
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_char
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       has_program_name;
  logic       skip_program_name;
  logic       cfg_wr;
  ctl_cmd_t   cmd;
  dp_status_t status;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      has_program_name  <= 1'b1;
      skip_program_name <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_HAS_PROG:  has_program_name  <= pwdata[0];
        REG_SKIP_PROG: skip_program_name <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_SKIP_PROG) ? {31'd0, skip_program_name}
                                               : {31'd0, has_program_name};

  clas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .status   (status),
    .cmd      (cmd)
  );

  clas_datapath #(
    .MAX_BACKSLASH_RUN (MAX_BACKSLASH_RUN)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .has_program_name  (has_program_name),
    .skip_program_name (skip_program_name),
    .req_type          (s_tuser),
    .in_char           (s_tdata),
    .cmd               (cmd),
    .status            (status),
    .kind              (m_tuser),
    .out_char          (m_tdata)
  );

  // Checks on the result sequencing.
`include "command_line_argument_splitter_core_assert.svh"

  `CLAS_ASSERT_IMPLY(a_busy_no_take, m_tvalid && !(m_tready && m_tlast), !s_tready, "input taken while results remain")
  `CLAS_ASSERT_IMPLY(a_lead_is_bsl, m_tvalid && !m_tlast, (m_tuser == K_CHAR) && (m_tdata == CH_BSL), "result before the last is not a backslash")
  `CLAS_ASSERT_IMPLY(a_nonchar_zero, m_tvalid && (m_tuser != K_CHAR), m_tdata == 8'd0, "non-character result carries data")

endmodule
